>>> rtl/vca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice channel allocator package
// Shared sizes, codes, table entry layout and the control and status groups
// passed between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
package vca_pkg;

    // Table size and derived widths.
    localparam int VOICES      = 128;
    localparam int VOICE_W     = $clog2(VOICES);
    localparam int CNT_W       = $clog2(VOICES + 1);
    localparam int OUT_VOICE_W = 7;
    localparam int IDX_EXT_W   = (VOICE_W > OUT_VOICE_W) ? VOICE_W : OUT_VOICE_W;

    // Field widths.
    localparam int ENTITY_W = 16;
    localparam int SUB_W    = 4;
    localparam int NOW_W    = 30;
    localparam int LEN_W    = 24;
    localparam int END_W    = 31;
    localparam int LIFE_W   = 32;

    // Remaining-life start value: the largest signed value, so any shorter life beats it.
    localparam logic signed [LIFE_W-1:0] BEST_INIT = 32'sh7fff_ffff;

    // Sub-channel codes.
    localparam logic [SUB_W-1:0] SUB_NONE = 4'h0;
    localparam logic [SUB_W-1:0] SUB_ANY  = 4'hF;

    // Operation codes.
    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_STOP     = 2'd1;
    localparam logic [1:0] OP_STOP_ALL = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER      = 1'd1;

    // One voice of the table.
    typedef struct packed {
        logic [ENTITY_W-1:0] entity;
        logic [SUB_W-1:0]    sub_channel;
        logic [END_W-1:0]    end_time;
        logic                active;
    } entry_t;

    // Sequencer to scan unit.
    typedef struct packed {
        logic                init;
        logic                eval;
        logic                is_start;
        logic [ENTITY_W-1:0] entity;
        logic [SUB_W-1:0]    sub_channel;
        logic [NOW_W-1:0]    now;
        logic [ENTITY_W-1:0] listener;
    } scan_ctrl_t;

    // Scan unit to sequencer.
    typedef struct packed {
        logic hit;
        logic found_next;
    } scan_stat_t;

endpackage

>>> rtl/vca_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice channel allocator channel interfaces
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface vca_in_if
    import vca_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic [ENTITY_W-1:0]      entity;
    logic signed [SUB_W-1:0]  sub_channel;
    logic [NOW_W-1:0]         now;
    logic [LEN_W-1:0]         sound_length;
    logic                     playable;

    modport source (
        output valid, opcode, entity, sub_channel, now, sound_length, playable,
        input  ready
    );
    modport sink (
        input  valid, opcode, entity, sub_channel, now, sound_length, playable,
        output ready
    );
endinterface

interface vca_out_if
    import vca_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   granted;
    logic [OUT_VOICE_W-1:0] voice;
    logic                   replaced_playing;

    modport source (
        output valid, granted, voice, replaced_playing,
        input  ready
    );
    modport sink (
        input  valid, granted, voice, replaced_playing,
        output ready
    );
endinterface

>>> rtl/vca_voice_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice table
// Voice memory with one write port, a separate registered read port and one valid bit per
// voice; a voice that is not valid reads as all zero.
// ----------------------------------------------------------------------------
module vca_voice_table
    import vca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [VOICE_W-1:0] rd_addr,
    input  logic               wr_en,
    input  logic [VOICE_W-1:0] wr_addr,
    input  entry_t             wr_data,
    input  logic               clear,
    output entry_t             rd_data,
    output logic [VOICE_W-1:0] rd_idx,
    output logic               rd_valid
);

    entry_t               mem [VOICES];
    entry_t               rd_word_reg;
    logic                 rd_bit_reg;
    logic [VOICE_W-1:0]   rd_idx_reg;
    logic                 rd_valid_reg;
    logic [VOICES-1:0]    valid_reg;

    // Memory array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // Valid bits and read bookkeeping; stop-all clears every bit at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_bit_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= rd_en;
            if (rd_en)
            begin
                rd_bit_reg <= valid_reg[rd_addr];
                rd_idx_reg <= rd_addr;
            end
        end
    end

    // A voice never written since reset or stop-all reads as zero.
    assign rd_data  = rd_bit_reg ? rd_word_reg : '0;
    assign rd_idx   = rd_idx_reg;
    assign rd_valid = rd_valid_reg;

endmodule

>>> rtl/vca_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice scan unit
// Shared match and remaining-life compare, applied to one voice per cycle;
// keeps the chosen voice, its previous active mark and the best life so far.
// ----------------------------------------------------------------------------
module vca_scan_unit
    import vca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scan_ctrl_t         ctrl,
    input  entry_t             entry,
    input  logic [VOICE_W-1:0] entry_idx,
    output scan_stat_t         stat,
    output logic               found,
    output logic [VOICE_W-1:0] pick,
    output logic               pick_was
);

    logic                     found_reg;
    logic [VOICE_W-1:0]       pick_reg;
    logic                     pick_was_reg;
    logic signed [LIFE_W-1:0] best_reg;
    logic signed [LIFE_W-1:0] life;
    logic                     same_owner;
    logic                     hit;
    logic                     guarded;
    logic                     take;

    // Owner match: reuse on start, exact match on stop.
    always_comb
    begin
        same_owner = (entry.entity == ctrl.entity);
        if (ctrl.is_start)
        begin
            hit = (ctrl.sub_channel != SUB_NONE) && same_owner &&
                  ((entry.sub_channel == ctrl.sub_channel) ||
                   (ctrl.sub_channel == SUB_ANY));
        end
        else
        begin
            hit = same_owner && (entry.sub_channel == ctrl.sub_channel);
        end
    end

    // Protection of the listener's playing voices and the life compare.
    always_comb
    begin
        guarded = (entry.entity == ctrl.listener) &&
                  (ctrl.entity != ctrl.listener) && entry.active;
        life    = $signed({1'b0, entry.end_time}) -
                  $signed({{(LIFE_W - NOW_W){1'b0}}, ctrl.now});
        take    = ctrl.is_start && !guarded && (life < best_reg);
    end

    assign stat.hit        = hit;
    assign stat.found_next = found_reg | (ctrl.eval & (hit | take));

    // Running choice.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            pick_reg     <= '0;
            pick_was_reg <= 1'b0;
            best_reg     <= BEST_INIT;
        end
        else if (ctrl.init)
        begin
            found_reg    <= 1'b0;
            pick_reg     <= '0;
            pick_was_reg <= 1'b0;
            best_reg     <= BEST_INIT;
        end
        else if (ctrl.eval && (hit || take))
        begin
            found_reg    <= 1'b1;
            pick_reg     <= entry_idx;
            pick_was_reg <= entry.active;
            if (!hit)
            begin
                best_reg <= life;
            end
        end
    end

    assign found    = found_reg;
    assign pick     = pick_reg;
    assign pick_was = pick_was_reg;

endmodule

>>> rtl/voice_channel_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice channel allocator core
// Start, stop and stop-all requests against a table of mixer voices.
// ----------------------------------------------------------------------------
// Start and stop read the table one voice per cycle through its registered
// read, then the chosen voice is written in S_WRITE and the result beat is
// loaded in S_DONE; a scan that picks no voice skips the write. A start that
// reuses a voice or a stop that finds it ends its scan early. Stop-all, a
// start with sound off and the unused code go to S_DONE. The next request is
// taken in the cycle after the result is loaded; a stalled result holds the
// block. Reset clears the registers and every valid bit at once; no sweep.
// ----------------------------------------------------------------------------
module voice_channel_allocator_core
    import vca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    vca_in_if.sink                in_ch,
    vca_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       issue_cnt_reg;
    logic [1:0]             op_reg;
    logic [ENTITY_W-1:0]    entity_reg;
    logic [SUB_W-1:0]       sub_reg;
    logic [NOW_W-1:0]       now_reg;
    logic [LEN_W-1:0]       len_reg;
    logic                   playable_reg;
    logic                   out_valid_reg;
    logic                   out_granted_reg;
    logic [OUT_VOICE_W-1:0] out_voice_reg;
    logic                   out_replaced_reg;
    logic                   sound_enabled_reg;
    logic [ENTITY_W-1:0]    listener_reg;

    logic                   accept;
    logic                   out_free;
    logic                   rd_en;
    logic                   tbl_clear;
    logic                   wr_en;
    entry_t                 wr_data;
    entry_t                 rd_data;
    logic [VOICE_W-1:0]     rd_idx;
    logic                   rd_valid;
    logic                   last_voice;
    scan_ctrl_t             scan_ctrl;
    scan_stat_t             scan_stat;
    logic                   found;
    logic [VOICE_W-1:0]     pick;
    logic                   pick_was;
    logic [IDX_EXT_W-1:0]   pick_ext;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_enabled_reg <= 1'b0;
            listener_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOUND_ENABLED: sound_enabled_reg <= cfg_wdata[0];
                CFG_LISTENER:      listener_reg      <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Handshakes and table control.
    always_comb
    begin
        in_ch.ready = (state_reg == S_IDLE);
        accept      = in_ch.valid && in_ch.ready;
        out_free    = !out_valid_reg || out_ch.ready;
        rd_en       = (state_reg == S_SCAN) && (issue_cnt_reg < CNT_W'(VOICES));
        tbl_clear   = accept && (in_ch.opcode == OP_STOP_ALL) && sound_enabled_reg;
        wr_en       = (state_reg == S_WRITE);
        last_voice  = (rd_idx == VOICE_W'(VOICES - 1));
    end

    // New contents of the chosen voice.
    always_comb
    begin
        wr_data.entity      = entity_reg;
        wr_data.sub_channel = sub_reg;
        if ((op_reg == OP_START) && playable_reg)
        begin
            wr_data.active   = 1'b1;
            wr_data.end_time = END_W'(now_reg) + END_W'(len_reg);
        end
        else
        begin
            wr_data.active   = 1'b0;
            wr_data.end_time = '0;
        end
    end

    // Scan unit control group.
    always_comb
    begin
        scan_ctrl.init        = accept;
        scan_ctrl.eval        = (state_reg == S_SCAN) && rd_valid;
        scan_ctrl.is_start    = (op_reg == OP_START);
        scan_ctrl.entity      = entity_reg;
        scan_ctrl.sub_channel = sub_reg;
        scan_ctrl.now         = now_reg;
        scan_ctrl.listener    = listener_reg;
    end

    vca_voice_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (issue_cnt_reg[VOICE_W-1:0]),
        .wr_en    (wr_en),
        .wr_addr  (pick),
        .wr_data  (wr_data),
        .clear    (tbl_clear),
        .rd_data  (rd_data),
        .rd_idx   (rd_idx),
        .rd_valid (rd_valid)
    );

    vca_scan_unit u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .entry     (rd_data),
        .entry_idx (rd_idx),
        .stat      (scan_stat),
        .found     (found),
        .pick      (pick),
        .pick_was  (pick_was)
    );

    assign pick_ext = IDX_EXT_W'(pick);

    // Sequencer, request latches and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            issue_cnt_reg    <= '0;
            op_reg           <= OP_START;
            entity_reg       <= '0;
            sub_reg          <= '0;
            now_reg          <= '0;
            len_reg          <= '0;
            playable_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_granted_reg  <= 1'b0;
            out_voice_reg    <= '0;
            out_replaced_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg        <= in_ch.opcode;
                        entity_reg    <= in_ch.entity;
                        sub_reg       <= in_ch.sub_channel;
                        now_reg       <= in_ch.now;
                        len_reg       <= in_ch.sound_length;
                        playable_reg  <= in_ch.playable;
                        issue_cnt_reg <= '0;
                        if (((in_ch.opcode == OP_START) && sound_enabled_reg) ||
                            (in_ch.opcode == OP_STOP))
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (rd_en)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                    end
                    if (scan_ctrl.eval)
                    begin
                        if (scan_stat.hit)
                        begin
                            state_reg <= S_WRITE;
                        end
                        else if (last_voice)
                        begin
                            state_reg <= scan_stat.found_next ? S_WRITE : S_DONE;
                        end
                    end
                end
                S_WRITE:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Result beat: load when the request finishes and the slot is free.
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg    <= 1'b1;
                out_granted_reg  <= found;
                out_voice_reg    <= found ? pick_ext[OUT_VOICE_W-1:0] : '0;
                out_replaced_reg <= found & pick_was;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.granted          = out_granted_reg;
    assign out_ch.voice            = out_voice_reg;
    assign out_ch.replaced_playing = out_replaced_reg;

`ifndef SYNTHESIS
    // A table write is always followed by the result cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (state_reg == S_DONE))
        else $error("table write not followed by result cycle");

    // The read counter never runs past the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        issue_cnt_reg <= CNT_W'(VOICES))
        else $error("scan read counter overran the table");

    // Only a start or a stop can grant a voice.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free && found) |->
            ((op_reg == OP_START) || (op_reg == OP_STOP)))
        else $error("grant reported for an operation that cannot grant");

    // The table is only cleared while sound is enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_clear |-> sound_enabled_reg)
        else $error("table cleared with sound disabled");

    // A scan only starts from a request beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && ($past(state_reg) == S_IDLE)) |->
            $past(accept))
        else $error("scan started without a request beat");
`endif

endmodule
